// ----- src/ode_pkg.sv -----
package ode_pkg;

    // default sizes
    localparam int LIST_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF   = 32;

    // fixed field widths on the ports
    localparam int IN_KEY_W  = 32;
    localparam int OUT_KEY_W = 32;
    localparam int OUT_CNT_W = 7;

    // request operation codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_FIND_DEL   = 3'd5,
        OP_SORT       = 3'd6,
        OP_CLEAR      = 3'd7
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_SORT   = 3'd3,
        CELL_CLEAR  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     parity;
    } t_cell_cmd;

endpackage

// ----- src/ordered_deque_engine.sv -----
// channel   direction  ports                               handshake
// request   in         i_op, i_key                         start && !busy
// result    out        o_out_key, o_status, o_entry_count  o_done, one cycle
//
// push, pop and clear are served from idle: the result strobes in the next cycle
// and busy stays low, so a new request can follow straight away.
// ordered insert and find-delete scan one cell a cycle from the front.
// sort runs LIST_DEPTH odd-even phases.
// synchronous active-low reset empties the list; no clearing pass.
// the receiver cannot stall: each result is present for exactly one cycle.
module ordered_deque_engine #(
    parameter int LIST_DEPTH = ode_pkg::LIST_DEPTH_DEF,
    parameter int KEY_BITS   = ode_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_op,
    input  logic [ode_pkg::IN_KEY_W-1:0]   i_key,
    output logic                           o_done,
    output logic [ode_pkg::OUT_KEY_W-1:0]  o_out_key,
    output logic [1:0]                     o_status,
    output logic [ode_pkg::OUT_CNT_W-1:0]  o_entry_count
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_SORT = 3'b100
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    ode_pkg::t_op            r_op;
    ode_pkg::t_op            n_op;
    logic [KEY_BITS-1:0]     r_key;
    logic [KEY_BITS-1:0]     n_key;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        n_idx;
    logic [IDX_W-1:0]        r_phase;
    logic [IDX_W-1:0]        n_phase;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_done;
    logic                    n_done;
    logic [KEY_BITS-1:0]     r_out_key;
    logic [KEY_BITS-1:0]     n_out_key;
    ode_pkg::t_status        r_status;
    ode_pkg::t_status        n_status;

    ode_pkg::t_op            w_op;
    logic [KEY_BITS-1:0]     w_in_key;
    logic [KEY_BITS-1:0]     w_req_key;
    ode_pkg::t_cell_cmd      w_cmd;
    logic [IDX_W-1:0]        w_pos;
    logic [KEY_BITS-1:0]     w_key   [LIST_DEPTH];
    logic                    w_valid [LIST_DEPTH];
    logic                    w_lt    [LIST_DEPTH];
    logic                    w_eq    [LIST_DEPTH];
    logic                    w_full;
    logic                    w_empty;
    logic                    w_last;
    logic                    w_hit;

    assign w_op      = ode_pkg::t_op'(i_op);
    assign w_in_key  = KEY_BITS'(i_key);
    assign w_req_key = (r_state == S_IDLE) ? w_in_key : r_key;
    assign w_full    = (r_count == CNT_W'(LIST_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_last    = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_hit     = (r_op == ode_pkg::OP_INSERT) ? !w_lt[r_idx] : w_eq[r_idx];

    // row of cells
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_lkey;
        logic                w_lvalid;
        logic [KEY_BITS-1:0] w_rkey;
        logic                w_rvalid;

        if (g == 0) begin : g_first
            assign w_lkey   = '0;
            assign w_lvalid = 1'b0;
        end else begin : g_mid_l
            assign w_lkey   = w_key[g-1];
            assign w_lvalid = w_valid[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_last
            assign w_rkey   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_mid_r
            assign w_rkey   = w_key[g+1];
            assign w_rvalid = w_valid[g+1];
        end

        ode_cell #(
            .LIST_DEPTH (LIST_DEPTH),
            .KEY_BITS   (KEY_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_pos         (w_pos),
            .i_req_key     (w_req_key),
            .i_left_key    (w_lkey),
            .i_left_valid  (w_lvalid),
            .i_right_key   (w_rkey),
            .i_right_valid (w_rvalid),
            .o_key         (w_key[g]),
            .o_valid       (w_valid[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // request decode, scan and sort sequencing
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_idx     = r_idx;
        n_phase   = r_phase;
        n_count   = r_count;
        n_done    = 1'b0;
        n_out_key = '0;
        n_status  = ode_pkg::ST_OK;
        w_cmd     = '{op: ode_pkg::CELL_HOLD, parity: 1'b0};
        w_pos     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = w_op;
                    n_key = w_in_key;
                    n_idx = '0;
                    unique case (w_op) inside
                        ode_pkg::OP_PUSH_FRONT,
                        ode_pkg::OP_PUSH_BACK,
                        ode_pkg::OP_INSERT: begin
                            if (w_full) begin
                                n_done   = 1'b1;
                                n_status = ode_pkg::ST_FULL;
                            end else if ((w_op == ode_pkg::OP_INSERT) && !w_empty) begin
                                n_state = S_SCAN;
                            end else begin
                                w_cmd.op = ode_pkg::CELL_INSERT;
                                w_pos    = (w_op == ode_pkg::OP_PUSH_BACK) ?
                                           IDX_W'(r_count) : '0;
                                n_count  = r_count + CNT_W'(1);
                                n_done   = 1'b1;
                            end
                        end
                        ode_pkg::OP_POP_FRONT,
                        ode_pkg::OP_POP_BACK: begin
                            n_done = 1'b1;
                            if (w_empty) begin
                                n_status = ode_pkg::ST_EMPTY;
                            end else begin
                                w_cmd.op  = ode_pkg::CELL_REMOVE;
                                w_pos     = (w_op == ode_pkg::OP_POP_BACK) ?
                                            IDX_W'(r_count - CNT_W'(1)) : '0;
                                n_out_key = w_key[w_pos];
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        ode_pkg::OP_FIND_DEL: begin
                            if (w_empty) begin
                                n_done   = 1'b1;
                                n_status = ode_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ode_pkg::OP_SORT: begin
                            n_state = S_SORT;
                            n_phase = '0;
                        end
                        ode_pkg::OP_CLEAR: begin
                            w_cmd.op = ode_pkg::CELL_CLEAR;
                            n_count  = '0;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    w_pos   = r_idx;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == ode_pkg::OP_INSERT) begin
                        w_cmd.op = ode_pkg::CELL_INSERT;
                        n_count  = r_count + CNT_W'(1);
                    end else begin
                        w_cmd.op = ode_pkg::CELL_REMOVE;
                        n_count  = r_count - CNT_W'(1);
                    end
                end else if (w_last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == ode_pkg::OP_INSERT) begin
                        // no key at or above: append at the back
                        w_cmd.op = ode_pkg::CELL_INSERT;
                        w_pos    = IDX_W'(r_count);
                        n_count  = r_count + CNT_W'(1);
                    end else begin
                        n_status = ode_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SORT: begin
                w_cmd.op     = ode_pkg::CELL_SORT;
                w_cmd.parity = r_phase[0];
                if (r_phase == IDX_W'(LIST_DEPTH - 1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_phase = r_phase + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_idx   <= n_idx;
            r_phase <= n_phase;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_out_key <= n_out_key;
        r_status  <= n_status;
    end

    // outputs
    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_out_key     = ode_pkg::OUT_KEY_W'(r_out_key);
    assign o_status      = r_status;
    assign o_entry_count = ode_pkg::OUT_CNT_W'(r_count);

endmodule

// ----- src/ode_cell.sv -----
module ode_cell #(
    parameter int LIST_DEPTH = ode_pkg::LIST_DEPTH_DEF,
    parameter int KEY_BITS   = ode_pkg::KEY_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ode_pkg::t_cell_cmd            i_cmd,
    input  logic [$clog2(LIST_DEPTH)-1:0] i_pos,
    input  logic [KEY_BITS-1:0]           i_req_key,
    input  logic [KEY_BITS-1:0]           i_left_key,
    input  logic                          i_left_valid,
    input  logic [KEY_BITS-1:0]           i_right_key,
    input  logic                          i_right_valid,
    output logic [KEY_BITS-1:0]           o_key,
    output logic                          o_valid,
    output logic                          o_lt,
    output logic                          o_eq
);

    localparam int   IDX_W = $clog2(LIST_DEPTH);
    localparam logic C_PAR = 1'(CELL_IDX % 2);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_valid;
    logic                n_valid;
    logic                w_at;
    logic                w_from_pos;

    assign w_at       = (IDX_W'(CELL_IDX) == i_pos);
    assign w_from_pos = (IDX_W'(CELL_IDX) >= i_pos);

    // next key and valid from the broadcast command and the neighbours
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        unique case (i_cmd.op)
            ode_pkg::CELL_INSERT: begin
                if (w_at) begin
                    n_key = i_req_key;
                end else if (w_from_pos) begin
                    n_key = i_left_key;
                end
                n_valid = r_valid | (w_from_pos & (w_at | i_left_valid));
            end
            ode_pkg::CELL_REMOVE: begin
                if (w_from_pos) begin
                    n_key   = i_right_key;
                    n_valid = i_right_valid;
                end
            end
            ode_pkg::CELL_SORT: begin
                if (C_PAR == i_cmd.parity) begin
                    // left member of a pair
                    if (r_valid && i_right_valid && (r_key > i_right_key)) begin
                        n_key = i_right_key;
                    end
                end else begin
                    // right member of a pair
                    if (i_left_valid && r_valid && (i_left_key > r_key)) begin
                        n_key = i_left_key;
                    end
                end
            end
            ode_pkg::CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_key   = r_key;
                n_valid = r_valid;
            end
        endcase
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key store
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    // local compares against the request key
    assign o_lt    = (r_key < i_req_key);
    assign o_eq    = (r_key == i_req_key);
    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

// ----- tb/ordered_deque_engine_tb.sv -----
`timescale 1ns / 1ps

module ordered_deque_engine_tb;

    localparam int LIST_DEPTH  = ode_pkg::LIST_DEPTH_DEF;
    localparam int KEY_BITS    = ode_pkg::KEY_BITS_DEF;
    localparam int IN_KEY_W    = ode_pkg::IN_KEY_W;
    localparam int OUT_KEY_W   = ode_pkg::OUT_KEY_W;
    localparam int OUT_CNT_W   = ode_pkg::OUT_CNT_W;
    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = LIST_DEPTH + 8;
    localparam int MODE_SPAN   = 160;

    typedef struct packed {
        logic [OUT_KEY_W-1:0] out_key;
        ode_pkg::t_status     status;
        logic [OUT_CNT_W-1:0] entry_count;
    } t_deque_result;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    logic [2:0]           i_op    = ode_pkg::OP_PUSH_FRONT;
    logic [IN_KEY_W-1:0]  i_key   = '0;
    logic                 busy;
    logic                 o_done;
    logic [OUT_KEY_W-1:0] o_out_key;
    logic [1:0]           o_status;
    logic [OUT_CNT_W-1:0] o_entry_count;

    // shadow copy of the list, packed from the front
    logic [KEY_BITS-1:0]  shadow_key [LIST_DEPTH];
    int                   shadow_count = 0;

    t_deque_result        expected_results [$];
    t_deque_result        want_result;
    int                   sender_idle_pct = 0;
    int                   error_count     = 0;
    int                   requests_sent   = 0;
    int                   results_checked = 0;
    int                   cycle_count     = 0;
    int                   full_hits       = 0;
    int                   empty_hits      = 0;
    int                   miss_hits       = 0;
    int                   peak_count      = 0;

    ordered_deque_engine #(
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_BITS   (KEY_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_key         (i_key),
        .o_done        (o_done),
        .o_out_key     (o_out_key),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("ordered_deque_engine_tb NOT OK");
            $finish;
        end
    end

    // apply one request to the shadow list and return the result it gives
    function automatic t_deque_result predict_deque(input ode_pkg::t_op op,
                                                    input logic [IN_KEY_W-1:0] key);
        t_deque_result       res;
        logic [KEY_BITS-1:0] k;
        logic [KEY_BITS-1:0] v;
        int                  pos;
        int                  j;
        res.out_key = '0;
        res.status  = ode_pkg::ST_OK;
        k           = key[KEY_BITS-1:0];
        case (op) inside
            ode_pkg::OP_PUSH_FRONT, ode_pkg::OP_PUSH_BACK, ode_pkg::OP_INSERT: begin
                if (shadow_count >= LIST_DEPTH) begin
                    res.status = ode_pkg::ST_FULL;
                    full_hits++;
                end else begin
                    if (op == ode_pkg::OP_PUSH_FRONT) begin
                        pos = 0;
                    end else if (op == ode_pkg::OP_PUSH_BACK) begin
                        pos = shadow_count;
                    end else begin
                        // before the first key that is not smaller
                        pos = 0;
                        while (pos < shadow_count && shadow_key[pos] < k) pos++;
                    end
                    for (j = shadow_count; j > pos; j--) shadow_key[j] = shadow_key[j-1];
                    shadow_key[pos] = k;
                    shadow_count++;
                end
            end
            ode_pkg::OP_POP_FRONT, ode_pkg::OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ode_pkg::ST_EMPTY;
                    empty_hits++;
                end else begin
                    pos = (op == ode_pkg::OP_POP_FRONT) ? 0 : shadow_count - 1;
                    res.out_key = OUT_KEY_W'(shadow_key[pos]);
                    for (j = pos; j + 1 < shadow_count; j++) shadow_key[j] = shadow_key[j+1];
                    shadow_count--;
                end
            end
            ode_pkg::OP_FIND_DEL: begin
                // exact match, first one from the front
                pos = 0;
                while (pos < shadow_count && shadow_key[pos] != k) pos++;
                if (pos >= shadow_count) begin
                    res.status = ode_pkg::ST_NOT_FOUND;
                    miss_hits++;
                end else begin
                    for (j = pos; j + 1 < shadow_count; j++) shadow_key[j] = shadow_key[j+1];
                    shadow_count--;
                end
            end
            ode_pkg::OP_SORT: begin
                for (pos = 1; pos < shadow_count; pos++) begin
                    v = shadow_key[pos];
                    j = pos;
                    while (j > 0 && shadow_key[j-1] > v) begin
                        shadow_key[j] = shadow_key[j-1];
                        j--;
                    end
                    shadow_key[j] = v;
                end
            end
            default: begin
                shadow_count = 0;
            end
        endcase
        if (shadow_count > peak_count) peak_count = shadow_count;
        res.entry_count = OUT_CNT_W'(shadow_count);
        return res;
    endfunction

    // send one request, with a random gap first when idling is on
    task automatic issue_request(input ode_pkg::t_op op, input logic [IN_KEY_W-1:0] key);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(predict_deque(op, key));
        requests_sent++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: key %h status %0d count %0d",
                       o_out_key, o_status, o_entry_count);
                error_count++;
            end else begin
                want_result = expected_results.pop_front();
                results_checked++;
                if (o_out_key !== want_result.out_key) begin
                    $error("out_key: expected %h, actual %h", want_result.out_key, o_out_key);
                    error_count++;
                end
                if (o_status !== want_result.status) begin
                    $error("status: expected %0d, actual %0d", want_result.status, o_status);
                    error_count++;
                end
                if (o_entry_count !== want_result.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want_result.entry_count, o_entry_count);
                    error_count++;
                end
            end
        end
    end

    // op mix leaning towards growth or towards shrinkage
    function automatic ode_pkg::t_op pick_op(input bit fill_mode);
        int r;
        r = $urandom_range(99);
        if (fill_mode) begin
            if (r < 20) return ode_pkg::OP_PUSH_FRONT;
            if (r < 42) return ode_pkg::OP_PUSH_BACK;
            if (r < 66) return ode_pkg::OP_INSERT;
            if (r < 74) return ode_pkg::OP_POP_FRONT;
            if (r < 82) return ode_pkg::OP_POP_BACK;
            if (r < 93) return ode_pkg::OP_FIND_DEL;
            if (r < 99) return ode_pkg::OP_SORT;
            return ode_pkg::OP_CLEAR;
        end
        if (r < 8)  return ode_pkg::OP_PUSH_FRONT;
        if (r < 16) return ode_pkg::OP_PUSH_BACK;
        if (r < 26) return ode_pkg::OP_INSERT;
        if (r < 46) return ode_pkg::OP_POP_FRONT;
        if (r < 66) return ode_pkg::OP_POP_BACK;
        if (r < 92) return ode_pkg::OP_FIND_DEL;
        if (r < 98) return ode_pkg::OP_SORT;
        return ode_pkg::OP_CLEAR;
    endfunction

    // keys: extremes, a narrow range for duplicates, held keys for hits, anything
    function automatic logic [IN_KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(15);
        if (sel < 2) begin
            if ($urandom_range(1) != 0) return {IN_KEY_W{1'b1}};
            return '0;
        end
        if (sel < 7) return IN_KEY_W'($urandom_range(15));
        if (sel < 11 && shadow_count > 0) return shadow_key[$urandom_range(shadow_count - 1)];
        return $urandom();
    endfunction

    // empty-list cases, extremes, duplicates and every op
    task automatic test_directed_cases();
        sender_idle_pct = 0;
        issue_request(ode_pkg::OP_POP_FRONT,  32'h0000_0000);
        issue_request(ode_pkg::OP_POP_BACK,   32'hFFFF_FFFF);
        issue_request(ode_pkg::OP_FIND_DEL,   32'h0000_0005);
        issue_request(ode_pkg::OP_SORT,       32'h0000_0000);
        issue_request(ode_pkg::OP_CLEAR,      32'h0000_0000);
        issue_request(ode_pkg::OP_PUSH_FRONT, 32'h0000_0000);
        issue_request(ode_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF);
        issue_request(ode_pkg::OP_INSERT,     32'h0000_0007);
        issue_request(ode_pkg::OP_INSERT,     32'h0000_0007);
        issue_request(ode_pkg::OP_INSERT,     32'h0000_0000);
        issue_request(ode_pkg::OP_INSERT,     32'hFFFF_FFFF);
        issue_request(ode_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        issue_request(ode_pkg::OP_FIND_DEL,   32'h0000_0007);
        issue_request(ode_pkg::OP_FIND_DEL,   32'h0001_2345);
        issue_request(ode_pkg::OP_SORT,       32'h5555_5555);
        issue_request(ode_pkg::OP_POP_FRONT,  32'hAAAA_AAAA);
        issue_request(ode_pkg::OP_POP_BACK,   32'h0000_0000);
        issue_request(ode_pkg::OP_INSERT,     32'h0000_0003);
        issue_request(ode_pkg::OP_PUSH_BACK,  32'h0000_0001);
        issue_request(ode_pkg::OP_FIND_DEL,   32'hFFFF_FFFF);
        issue_request(ode_pkg::OP_POP_FRONT,  32'h0000_0000);
        issue_request(ode_pkg::OP_POP_BACK,   32'h0000_0000);
        issue_request(ode_pkg::OP_CLEAR,      32'hFFFF_FFFF);
        issue_request(ode_pkg::OP_POP_BACK,   32'h0000_0000);
    endtask

    // fill to the limit, push into a full list, then drain past empty
    task automatic test_full_and_empty();
        int i;
        sender_idle_pct = 18;
        issue_request(ode_pkg::OP_CLEAR, $urandom());
        for (i = 0; i < LIST_DEPTH; i++) begin
            case (i % 3)
                0:       issue_request(ode_pkg::OP_PUSH_FRONT, $urandom());
                1:       issue_request(ode_pkg::OP_PUSH_BACK,  $urandom());
                default: issue_request(ode_pkg::OP_INSERT,     $urandom());
            endcase
        end
        issue_request(ode_pkg::OP_PUSH_FRONT, $urandom());
        issue_request(ode_pkg::OP_PUSH_BACK,  $urandom());
        issue_request(ode_pkg::OP_INSERT,     $urandom());
        issue_request(ode_pkg::OP_FIND_DEL,   shadow_key[LIST_DEPTH / 2]);
        issue_request(ode_pkg::OP_INSERT,     32'h0000_0000);
        issue_request(ode_pkg::OP_SORT,       $urandom());
        issue_request(ode_pkg::OP_INSERT,     32'hFFFF_FFFF);
        issue_request(ode_pkg::OP_FIND_DEL,   shadow_key[LIST_DEPTH - 1]);
        issue_request(ode_pkg::OP_FIND_DEL,   shadow_key[0]);
        for (i = 0; i < LIST_DEPTH; i++) begin
            if (i % 2 == 0) issue_request(ode_pkg::OP_POP_FRONT, $urandom());
            else            issue_request(ode_pkg::OP_POP_BACK,  $urandom());
        end
        issue_request(ode_pkg::OP_POP_FRONT, $urandom());
        issue_request(ode_pkg::OP_POP_BACK,  $urandom());
        issue_request(ode_pkg::OP_FIND_DEL,  $urandom());
    endtask

    // random traffic, swinging between growth and shrinkage
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        bit fill_mode;
        fill_mode       = 1'b1;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % MODE_SPAN == MODE_SPAN - 1) fill_mode = !fill_mode;
            issue_request(pick_op(fill_mode), pick_key());
        end
    endtask

    // main sequence
    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_full_and_empty();
        test_random_traffic(600, 0);
        test_random_traffic(600, 60);
        test_random_traffic(385, 18);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("%0d requests sent and %0d results checked, sender idle 0, 60 and 18 pct",
                 requests_sent, results_checked);
        $display("full %0d, empty %0d, not found %0d, peak occupancy %0d of %0d",
                 full_hits, empty_hits, miss_hits, peak_count, LIST_DEPTH);
        if (error_count == 0) begin
            $display("ordered_deque_engine_tb OK");
        end else begin
            $display("ordered_deque_engine_tb NOT OK");
        end
        $finish;
    end

endmodule
